### design/cic_pkg.sv
// Shared types, codes, constants and a priority function for the cascaded interrupt controller.
`default_nettype none

package cic_pkg;

    typedef enum logic [2:0] {
        FUNC_CMD_WRITE  = 3'd0,
        FUNC_DATA_WRITE = 3'd1,
        FUNC_CMD_READ   = 3'd2,
        FUNC_DATA_READ  = 3'd3,
        FUNC_RAISE      = 3'd4,
        FUNC_LOWER      = 3'd5,
        FUNC_SERVICE    = 3'd6
    } func_t;

    typedef struct packed {
        func_t      func;
        logic       chip_select;
        logic [7:0] write_value;
        logic [3:0] irq_line;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic       intr_valid;
        logic [7:0] intr_vector;
    } out_item_t;

    localparam logic [15:0] MASK_RESET         = 16'hFEF8;
    localparam logic [4:0]  MASTER_BASE_RESET  = 5'd1;
    localparam logic [4:0]  SLAVE_BASE_RESET   = 5'd14;
    localparam logic [4:0]  NO_LINE            = 5'd16;
    localparam logic [15:0] SLAVE_LINES        = 16'hFF00;

    // Cascade priority: master lines 0-2, the slave lines on line 2, then master 3-7.
    localparam logic [3:0] SCAN_ORDER [16] = '{
        4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12,
        4'd13, 4'd14, 4'd15, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
    };

    // Position of each line in the scan order.
    localparam logic [3:0] LINE_RANK [16] = '{
        4'd0, 4'd1, 4'd2, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10
    };

    // First set line in scan order, or NO_LINE when none is set.
    function automatic logic [4:0] first_in_order(input logic [15:0] bits);
        logic [4:0] res;
        res = NO_LINE;
        for (int j = 15; j >= 0; j--) begin
            if (bits[SCAN_ORDER[j]]) begin
                res = {1'b0, SCAN_ORDER[j]};
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/cascaded_interrupt_controller_core.sv
// Top level of the cascaded interrupt controller: master and slave pair with 16 lines.
`default_nettype none

// A master/slave pair of 8259-style controllers seen as one 16-line unit. Each input
// item is a port access, a line raise or lower, or a service attempt, and each one gives
// exactly one result item. An item is registered on acceptance, processed by one level
// of logic (a 16-line priority encoder over the cascade order), and its result lands
// in an output register, so a new item is taken every cycle while the result side
// keeps up. The output register is the only buffer: when a result waits, the next item
// is held in the input register and input acceptance stops until the result is taken.
module cascaded_interrupt_controller_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cic_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cic_pkg::out_item_t     m_item
);

    // Pipeline registers.
    logic               in_valid_reg;
    cic_pkg::in_item_t  in_reg;
    logic               out_valid_reg;
    cic_pkg::out_item_t out_reg;
    cic_pkg::out_item_t out_next;
    logic               advance;

    // Controller state.
    logic [15:0] mask_reg, mask_next;
    logic [15:0] req_reg, req_next;
    logic [15:0] isr_reg, isr_next;
    logic [4:0]  active_reg, active_next;
    logic [4:0]  vbase_reg [2];
    logic [4:0]  vbase_next [2];
    logic [1:0]  init_step_reg [2];
    logic [1:0]  init_step_next [2];
    logic [1:0]  init_words_reg [2];
    logic [1:0]  init_words_next [2];
    logic [1:0]  single_reg, single_next;
    logic [1:0]  aeoi_reg, aeoi_next;
    logic [1:0]  rot_aeoi_reg, rot_aeoi_next;
    logic [1:0]  ris_reg, ris_next;
    logic [1:0]  smm_reg, smm_next;

    // Decode helpers.
    logic        cs;
    logic [7:0]  v;
    logic [15:0] eoi_clear;
    logic [4:0]  after_eoi_line;
    logic [4:0]  prio;
    logic        any_special;
    logic [15:0] eligible;
    logic [4:0]  svc_line;
    logic        svc_chip;
    logic [1:0]  cur_step;
    logic [1:0]  cur_words;
    logic [1:0]  step_after;
    logic [7:0]  req_byte;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    assign cs = in_reg.chip_select;
    assign v  = in_reg.write_value;

    // Ending the active line and choosing the next in-service line.
    assign eoi_clear      = active_reg[4] ? 16'h0000 : (16'h0001 << active_reg[3:0]);
    assign after_eoi_line = cic_pkg::first_in_order(isr_reg & ~eoi_clear);

    // Lines offered to a service attempt.
    assign prio        = active_reg[4] ? cic_pkg::NO_LINE
                                       : {1'b0, cic_pkg::LINE_RANK[active_reg[3:0]]};
    assign any_special = smm_reg[0] || smm_reg[1];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            eligible[i] = (({1'b0, cic_pkg::LINE_RANK[i]} < prio)
                           || (any_special && smm_reg[i / 8]))
                          && !mask_reg[i] && req_reg[i]
                          && !(i > 7 && mask_reg[2]);
        end
    end

    assign svc_line = cic_pkg::first_in_order(eligible);
    assign svc_chip = svc_line[3];

    // Initialization word sequencing for the addressed chip.
    assign cur_step  = init_step_reg[cs];
    assign cur_words = init_words_reg[cs];

    always_comb begin
        if (cur_step >= cur_words) begin
            step_after = 2'd0;
        end else if (cur_step == 2'd1 && single_reg[cs]) begin
            step_after = (cur_words == 2'd3) ? 2'd3 : 2'd0;
        end else begin
            step_after = cur_step + 2'd1;
        end
    end

    // The master request byte also shows line 2 while line 2 is unmasked and an open slave line is requesting.
    always_comb begin
        if (cs) begin
            req_byte = req_reg[15:8];
        end else begin
            req_byte = req_reg[7:0];
            if (!mask_reg[2] && ((req_reg & ~mask_reg & cic_pkg::SLAVE_LINES) != 16'h0000)) begin
                req_byte[2] = 1'b1;
            end
        end
    end

    always_comb begin
        mask_next       = mask_reg;
        req_next        = req_reg;
        isr_next        = isr_reg;
        active_next     = active_reg;
        vbase_next      = vbase_reg;
        init_step_next  = init_step_reg;
        init_words_next = init_words_reg;
        single_next     = single_reg;
        aeoi_next       = aeoi_reg;
        rot_aeoi_next   = rot_aeoi_reg;
        ris_next        = ris_reg;
        smm_next        = smm_reg;
        out_next        = '0;

        unique case (in_reg.func)
            cic_pkg::FUNC_CMD_WRITE: begin
                if (v[4]) begin
                    single_next[cs]     = v[1];
                    init_step_next[cs]  = 2'd1;
                    init_words_next[cs] = {1'b1, v[0]};
                end else if (v[3]) begin
                    if (v[1]) begin
                        ris_next[cs] = v[0];
                    end
                    if (v[6]) begin
                        smm_next[cs] = v[5];
                    end
                end else if (v[5]) begin
                    if (v[6]) begin
                        if (active_reg == {1'b0, cs, v[2:0]}) begin
                            isr_next    = isr_reg & ~eoi_clear;
                            active_next = after_eoi_line;
                        end
                    end else if (cs ? !active_reg[4] : (active_reg < 5'd8)) begin
                        isr_next    = isr_reg & ~eoi_clear;
                        active_next = after_eoi_line;
                    end
                end else if (!v[6]) begin
                    rot_aeoi_next[cs] = v[7];
                end
            end
            cic_pkg::FUNC_DATA_WRITE: begin
                case (cur_step)
                    2'd0: begin
                        if (cs) begin
                            mask_next[15:8] = v;
                        end else begin
                            mask_next[7:0] = v;
                        end
                    end
                    2'd1: begin
                        vbase_next[cs]     = v[7:3];
                        init_step_next[cs] = step_after;
                    end
                    2'd2: begin
                        init_step_next[cs] = step_after;
                    end
                    default: begin
                        aeoi_next[cs]      = v[1];
                        init_step_next[cs] = step_after;
                    end
                endcase
            end
            cic_pkg::FUNC_CMD_READ: begin
                if (ris_reg[cs]) begin
                    out_next.read_value = cs ? isr_reg[15:8] : isr_reg[7:0];
                end else begin
                    out_next.read_value = req_byte;
                end
            end
            cic_pkg::FUNC_DATA_READ: begin
                out_next.read_value = cs ? mask_reg[15:8] : mask_reg[7:0];
            end
            cic_pkg::FUNC_RAISE: begin
                req_next = req_reg | (16'h0001 << in_reg.irq_line);
            end
            cic_pkg::FUNC_LOWER: begin
                req_next = req_reg & ~(16'h0001 << in_reg.irq_line);
            end
            cic_pkg::FUNC_SERVICE: begin
                if (!svc_line[4]) begin
                    req_next             = req_reg & ~(16'h0001 << svc_line[3:0]);
                    out_next.intr_valid  = 1'b1;
                    out_next.intr_vector = {vbase_reg[svc_chip], svc_line[2:0]};
                    if (!aeoi_reg[svc_chip]) begin
                        active_next = svc_line;
                        isr_next    = isr_reg | (16'h0001 << svc_line[3:0]);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            mask_reg           <= cic_pkg::MASK_RESET;
            req_reg            <= 16'h0000;
            isr_reg            <= 16'h0000;
            active_reg         <= cic_pkg::NO_LINE;
            vbase_reg[0]       <= cic_pkg::MASTER_BASE_RESET;
            vbase_reg[1]       <= cic_pkg::SLAVE_BASE_RESET;
            init_step_reg[0]   <= 2'd0;
            init_step_reg[1]   <= 2'd0;
            init_words_reg[0]  <= 2'd0;
            init_words_reg[1]  <= 2'd0;
            single_reg         <= 2'b00;
            aeoi_reg           <= 2'b00;
            rot_aeoi_reg       <= 2'b00;
            ris_reg            <= 2'b00;
            smm_reg            <= 2'b00;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && advance) begin
                mask_reg       <= mask_next;
                req_reg        <= req_next;
                isr_reg        <= isr_next;
                active_reg     <= active_next;
                vbase_reg      <= vbase_next;
                init_step_reg  <= init_step_next;
                init_words_reg <= init_words_next;
                single_reg     <= single_next;
                aeoi_reg       <= aeoi_next;
                rot_aeoi_reg   <= rot_aeoi_next;
                ris_reg        <= ris_next;
                smm_reg        <= smm_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_item;
        end
        if (in_valid_reg && advance) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the cascaded interrupt controller core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CYCLES   = 200000;
    localparam int RANDOM_ITEMS = 500;

    // Tracks the expected controller state and the replies still owed by the block.
    class pic_scoreboard;
        logic [15:0] mask_bits;
        logic [15:0] request_bits;
        logic [15:0] in_service_bits;
        logic [4:0]  vector_base [2];
        logic [4:0]  active_line;
        logic [1:0]  init_step [2];
        logic [1:0]  init_words [2];
        logic        single_mode [2];
        logic        aeoi_mode [2];
        logic        rotate_on_aeoi [2];
        logic        read_in_service [2];
        logic        special_mask [2];
        cic_pkg::out_item_t expected_replies [$];
        int          errors;

        function new();
            mask_bits       = 16'hFEF8;
            request_bits    = '0;
            in_service_bits = '0;
            vector_base[0]  = 5'd1;
            vector_base[1]  = 5'd14;
            active_line     = 5'd16;
            for (int c = 0; c < 2; c++) begin
                init_step[c]       = '0;
                init_words[c]      = '0;
                single_mode[c]     = 1'b0;
                aeoi_mode[c]       = 1'b0;
                rotate_on_aeoi[c]  = 1'b0;
                read_in_service[c] = 1'b0;
                special_mask[c]    = 1'b0;
            end
            errors = 0;
        endfunction

        // Cascade order: master 0-2, slave 8-15, then master 3-7.
        function int order_at(int j);
            if (j < 3) return j;
            if (j < 11) return j + 5;
            return j - 8;
        endfunction

        function int rank_of(int line);
            if (line >= 16) return 16;
            if (line < 3) return line;
            if (line < 8) return line + 8;
            return line - 5;
        endfunction

        function void pick_active();
            active_line = 5'd16;
            for (int j = 0; j < 16; j++) begin
                if (in_service_bits[order_at(j)]) begin
                    active_line = 5'(order_at(j));
                    return;
                end
            end
        endfunction

        function void finish_active();
            if (active_line < 16) in_service_bits[active_line[3:0]] = 1'b0;
            pick_active();
        endfunction

        function void command_write(int c, logic [7:0] v);
            int base;
            base = c * 8;
            if (v[4]) begin
                single_mode[c] = v[1];
                init_step[c]   = 2'd1;
                init_words[c]  = 2'd2 + 2'(v[0]);
            end else if (v[3]) begin
                if (v[1]) read_in_service[c] = v[0];
                if (v[6]) special_mask[c] = v[5];
            end else if (v[5]) begin
                if (v[6]) begin
                    if (int'(active_line) == base + int'(v[2:0])) finish_active();
                end else if (int'(active_line) < base + 8) begin
                    finish_active();
                end
            end else if (!v[6]) begin
                rotate_on_aeoi[c] = v[7];
            end
        endfunction

        function void advance_init(int c);
            if (init_step[c] >= init_words[c]) init_step[c] = 2'd0;
            else if (init_step[c] == 2'd1 && single_mode[c])
                init_step[c] = (init_words[c] >= 2'd3) ? 2'd3 : 2'd0;
            else init_step[c] = init_step[c] + 2'd1;
        endfunction

        function void data_write(int c, logic [7:0] v);
            case (init_step[c])
                2'd0: begin
                    if (c != 0) mask_bits[15:8] = v;
                    else mask_bits[7:0] = v;
                end
                2'd1: begin
                    vector_base[c] = v[7:3];
                    advance_init(c);
                end
                2'd2: advance_init(c);
                default: begin
                    aeoi_mode[c] = v[1];
                    advance_init(c);
                end
            endcase
        endfunction

        function logic [7:0] command_read(int c);
            logic [7:0] r;
            if (read_in_service[c]) return c ? in_service_bits[15:8] : in_service_bits[7:0];
            r = c ? request_bits[15:8] : request_bits[7:0];
            // The master shows the cascade line while it is unmasked and an open slave line requests.
            if (c == 0 && !mask_bits[2] && |(request_bits & ~mask_bits & 16'hFF00)) r[2] = 1'b1;
            return r;
        endfunction

        function bit try_service(output logic [7:0] vec);
            int rank_limit;
            int line;
            int c;
            bit any_special;
            vec = '0;
            rank_limit = rank_of(int'(active_line));
            any_special = special_mask[0] || special_mask[1];
            for (int j = 0; j < 16; j++) begin
                line = order_at(j);
                c = line / 8;
                if (!(j < rank_limit || (any_special && special_mask[c]))) continue;
                if (mask_bits[line] || !request_bits[line]) continue;
                if (line > 7 && mask_bits[2]) continue;
                request_bits[line] = 1'b0;
                vec = {vector_base[c], 3'b000} | 8'(line % 8);
                if (!aeoi_mode[c]) begin
                    active_line = 5'(line);
                    in_service_bits[line] = 1'b1;
                end
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function cic_pkg::out_item_t predict_reply(cic_pkg::in_item_t it);
            cic_pkg::out_item_t r;
            int c;
            logic [7:0] vec;
            r = '0;
            c = int'(it.chip_select);
            case (it.func)
                cic_pkg::FUNC_CMD_WRITE:  command_write(c, it.write_value);
                cic_pkg::FUNC_DATA_WRITE: data_write(c, it.write_value);
                cic_pkg::FUNC_CMD_READ:   r.read_value = command_read(c);
                cic_pkg::FUNC_DATA_READ:  r.read_value = c ? mask_bits[15:8] : mask_bits[7:0];
                cic_pkg::FUNC_RAISE:      request_bits[it.irq_line] = 1'b1;
                cic_pkg::FUNC_LOWER:      request_bits[it.irq_line] = 1'b0;
                cic_pkg::FUNC_SERVICE: begin
                    if (try_service(vec)) begin
                        r.intr_valid  = 1'b1;
                        r.intr_vector = vec;
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_access(cic_pkg::in_item_t it);
            expected_replies.push_back(predict_reply(it));
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(cic_pkg::out_item_t got);
            cic_pkg::out_item_t want;
            if (expected_replies.size() == 0) begin
                report($sformatf("unexpected result rd=%02h v=%0b vec=%02h",
                                 got.read_value, got.intr_valid, got.intr_vector));
                return;
            end
            want = expected_replies.pop_front();
            if (got.read_value !== want.read_value)
                report($sformatf("read_value %02h, expected %02h", got.read_value,
                                 want.read_value));
            if (got.intr_valid !== want.intr_valid)
                report($sformatf("intr_valid %0b, expected %0b", got.intr_valid,
                                 want.intr_valid));
            if (got.intr_vector !== want.intr_vector)
                report($sformatf("intr_vector %02h, expected %02h", got.intr_vector,
                                 want.intr_vector));
        endtask
    endclass

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    cic_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    cic_pkg::out_item_t m_item;

    pic_scoreboard sb;
    int items_sent;
    int cycles;

    cascaded_interrupt_controller_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic cic_pkg::in_item_t access(cic_pkg::func_t f, logic cs, logic [7:0] v,
                                                 logic [3:0] line);
        cic_pkg::in_item_t it;
        it.func        = f;
        it.chip_select = cs;
        it.write_value = v;
        it.irq_line    = line;
        return it;
    endfunction

    function automatic logic [7:0] sparse_byte();
        return 8'($urandom & $urandom & $urandom);
    endfunction

    task automatic send_item(input cic_pkg::in_item_t it);
        int gap;
        gap = (items_sent >= 100 && items_sent < 180) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_access(it);
        items_sent++;
    endtask

    // Stops offering items until the block has returned every reply.
    task automatic wait_for_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_replies.size() != 0);
    endtask

    task automatic send_init_sequence();
        logic       cs;
        logic [7:0] icw1;
        cs   = 1'($urandom_range(0, 1));
        icw1 = 8'($urandom) | 8'h10;
        send_item(access(cic_pkg::FUNC_CMD_WRITE, cs, icw1, 4'($urandom)));
        send_item(access(cic_pkg::FUNC_DATA_WRITE, cs, 8'($urandom), 4'($urandom)));
        if (!icw1[1])
            send_item(access(cic_pkg::FUNC_DATA_WRITE, cs, 8'($urandom), 4'($urandom)));
        if (icw1[0])
            send_item(access(cic_pkg::FUNC_DATA_WRITE, cs, 8'($urandom), 4'($urandom)));
        send_item(access(cic_pkg::FUNC_DATA_WRITE, cs, sparse_byte(), 4'($urandom)));
    endtask

    task automatic send_random_access();
        cic_pkg::in_item_t it;
        int pick;
        int kind;
        it.chip_select = 1'($urandom_range(0, 1));
        it.write_value = 8'($urandom);
        it.irq_line    = 4'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            send_init_sequence();
            return;
        end
        if (pick < 26) it.func = cic_pkg::FUNC_RAISE;
        else if (pick < 32) it.func = cic_pkg::FUNC_LOWER;
        else if (pick < 55) it.func = cic_pkg::FUNC_SERVICE;
        else if (pick < 68) begin
            it.func = cic_pkg::FUNC_CMD_WRITE;
            kind = $urandom_range(0, 9);
            // Mostly end-of-interrupt and read/mask commands, some raw bytes.
            if (kind < 3) it.write_value = (it.write_value & 8'h87) | 8'h20;
            else if (kind < 5) it.write_value = (it.write_value & 8'h87) | 8'h60;
            else if (kind < 7) it.write_value = (it.write_value & 8'hE7) | 8'h08;
            else if (kind < 8) it.write_value = it.write_value & 8'hC7;
        end else if (pick < 76) begin
            it.func = cic_pkg::FUNC_DATA_WRITE;
            kind = $urandom_range(0, 9);
            if (kind < 6) it.write_value = sparse_byte();
            else if (kind < 7) it.write_value = 8'hFF;
        end else if (pick < 88) it.func = cic_pkg::FUNC_CMD_READ;
        else it.func = cic_pkg::FUNC_DATA_READ;
        send_item(it);
    endtask

    initial begin : stimulus
        int random_start;
        bit paused;
        sb = new();
        items_sent = 0;
        paused = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(access(cic_pkg::FUNC_CMD_READ,   1'b0, 8'h00, 4'd0));
        send_item(access(cic_pkg::FUNC_DATA_READ,  1'b1, 8'h00, 4'd0));
        send_item(access(cic_pkg::FUNC_RAISE,      1'b0, 8'h00, 4'd0));
        send_item(access(cic_pkg::FUNC_RAISE,      1'b1, 8'hFF, 4'd15));
        send_item(access(cic_pkg::FUNC_SERVICE,    1'b0, 8'h00, 4'd0));
        send_item(access(cic_pkg::FUNC_DATA_WRITE, 1'b1, 8'h00, 4'd0));
        // A requesting, open slave line shows up as the master's cascade request.
        send_item(access(cic_pkg::FUNC_CMD_READ,   1'b0, 8'h00, 4'd0));
        send_item(access(cic_pkg::FUNC_CMD_WRITE,  1'b0, 8'h20, 4'd0));
        send_item(access(cic_pkg::FUNC_SERVICE,    1'b0, 8'h00, 4'd0));
        send_item(access(cic_pkg::FUNC_CMD_WRITE,  1'b1, 8'h0B, 4'd0));
        send_item(access(cic_pkg::FUNC_CMD_READ,   1'b1, 8'h00, 4'd0));
        send_item(access(cic_pkg::FUNC_CMD_WRITE,  1'b1, 8'h67, 4'd0));
        // Slave line requesting while the master's cascade line is masked.
        send_item(access(cic_pkg::FUNC_DATA_WRITE, 1'b0, 8'h04, 4'd0));
        send_item(access(cic_pkg::FUNC_RAISE,      1'b0, 8'h00, 4'd9));
        send_item(access(cic_pkg::FUNC_SERVICE,    1'b0, 8'h00, 4'd0));
        send_item(access(cic_pkg::FUNC_CMD_WRITE,  1'b0, 8'h11, 4'd0));
        send_item(access(cic_pkg::FUNC_DATA_WRITE, 1'b0, 8'hFF, 4'd0));
        send_item(access(cic_pkg::FUNC_DATA_WRITE, 1'b0, 8'h04, 4'd0));
        send_item(access(cic_pkg::FUNC_DATA_WRITE, 1'b0, 8'h02, 4'd0));
        send_item(access(cic_pkg::FUNC_DATA_WRITE, 1'b0, 8'h00, 4'd0));
        send_item(access(cic_pkg::FUNC_SERVICE,    1'b0, 8'h00, 4'd0));
        // Slave in single mode skips the cascade word and goes on to auto-EOI.
        send_item(access(cic_pkg::FUNC_CMD_WRITE,  1'b1, 8'h13, 4'd0));
        send_item(access(cic_pkg::FUNC_DATA_WRITE, 1'b1, 8'h00, 4'd0));
        send_item(access(cic_pkg::FUNC_DATA_WRITE, 1'b1, 8'h03, 4'd0));
        send_item(access(cic_pkg::FUNC_CMD_WRITE,  1'b0, 8'h68, 4'd0));
        send_item(access(cic_pkg::FUNC_RAISE,      1'b0, 8'h00, 4'd7));
        send_item(access(cic_pkg::FUNC_SERVICE,    1'b0, 8'h00, 4'd0));
        send_item(access(cic_pkg::FUNC_CMD_WRITE,  1'b0, 8'h80, 4'd0));
        send_item(access(cic_pkg::FUNC_CMD_WRITE,  1'b0, 8'hC0, 4'd0));
        send_item(access(cic_pkg::FUNC_CMD_WRITE,  1'b1, 8'h20, 4'd0));
        send_item(access(cic_pkg::FUNC_LOWER,      1'b0, 8'h00, 4'd9));
        wait_for_replies();

        random_start = items_sent;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            if (!paused && items_sent >= random_start + 250) begin
                wait_for_replies();
                paused = 1'b1;
            end
            send_random_access();
        end
        s_valid <= 1'b0;

        while (sb.expected_replies.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin : result_side
        int stall_left;
        int hold_left;
        int taken;
        stall_left = 0;
        hold_left  = 0;
        taken      = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result(m_item);
                taken++;
                stall_left = (taken >= 300 && taken < 380) ? 0 : $urandom_range(0, 9);
                // Long hold-offs let the block fill up and stall its input.
                if (taken == 150 || taken == 420) hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < MAX_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

endmodule

### cascaded_interrupt_controller_core.f
design/cic_pkg.sv
design/cascaded_interrupt_controller_core.sv
test/testbench.sv
